/* rtl/core/vgcd_pkg.sv */
// ----------------------------------------------------------------------------
// vgcd_pkg
// Shared widths, defaults and reset values of the voxel grid centroid
// downsampler.
// ----------------------------------------------------------------------------
package vgcd_pkg;

    localparam int COORD_W       = 16;   // point and mean coordinate width
    localparam int VOXEL_W       = 16;   // voxel_size register width
    localparam int CELL_PTS_W    = 11;   // cell_points result width
    localparam int DEF_MAX_POINTS = 1024;
    localparam int DEF_GRID_DIM   = 16;

    localparam logic [VOXEL_W-1:0] VOXEL_RESET = 16'd100;

endpackage

/* rtl/core/vgcd_ram.sv */
// ----------------------------------------------------------------------------
// vgcd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module vgcd_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/vgcd_divider.sv */
// ----------------------------------------------------------------------------
// vgcd_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vgcd_divider #(
    parameter int DW = 26,
    parameter int VW = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient,
    output logic          rem_nz
);

    localparam int CNTW = $clog2(DW + 1);

    logic [VW-1:0]   rem_reg;
    logic [VW-1:0]   rem_next;
    logic [DW-1:0]   quo_reg;
    logic [DW-1:0]   quo_next;
    logic [VW-1:0]   div_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [VW:0]     shifted;
    logic [VW:0]     trial;
    logic            ge;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DW-1]};
        trial    = shifted - {1'b0, div_reg};
        ge       = (shifted >= {1'b0, div_reg});
        rem_next = ge ? trial[VW-1:0] : shifted[VW-1:0];
        quo_next = {quo_reg[DW-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            quo_reg  <= '0;
            div_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend;
            div_reg  <= divisor;
            cnt_reg  <= CNTW'(DW);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            cnt_reg  <= cnt_reg - 1'b1;
            // last bit: hand the result over next cycle
            if (cnt_reg == CNTW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = (rem_reg != '0);

endmodule

/* rtl/core/voxel_grid_centroid_downsampler_top.sv */
// ----------------------------------------------------------------------------
// voxel_grid_centroid_downsampler_top
// Loads points into a buffer, bins them into a cubic voxel grid on the first
// drain request and returns one centroid or zero result per drain request.
// ----------------------------------------------------------------------------
// Load transaction (mode 0): taken while idle, ready again the next cycle.
// First drain of a cloud: a minimum pass over the points, a clear of the grid,
//   binning (three divisions per point), then a scan of the cells and three
//   divisions for the mean. Later drains: the scan and the mean divisions.
// All divisions share the single divider; cells are read through the
//   registered read port of the cell memory.
// Reset: control state clears at once; memories need no clearing pass, the
//   cell memory is swept to zero at the start of every cloud's binning.
// ----------------------------------------------------------------------------
module voxel_grid_centroid_downsampler_top #(
    parameter int MAX_POINTS = vgcd_pkg::DEF_MAX_POINTS,
    parameter int GRID_DIM   = vgcd_pkg::DEF_GRID_DIM
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [vgcd_pkg::VOXEL_W-1:0]           cfg_voxel_size,
    // input channel
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic                                   mode,
    input  logic signed [vgcd_pkg::COORD_W-1:0]    coord_x,
    input  logic signed [vgcd_pkg::COORD_W-1:0]    coord_y,
    input  logic signed [vgcd_pkg::COORD_W-1:0]    coord_z,
    // result channel
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [vgcd_pkg::COORD_W-1:0]    mean_x,
    output logic signed [vgcd_pkg::COORD_W-1:0]    mean_y,
    output logic signed [vgcd_pkg::COORD_W-1:0]    mean_z,
    output logic [vgcd_pkg::CELL_PTS_W-1:0]        cell_points,
    output logic                                   last_cell,
    output logic                                   cloud_empty,
    output logic                                   points_dropped
);

    import vgcd_pkg::*;

    // Derived sizes
    localparam int PAW   = $clog2(MAX_POINTS);            // point address
    localparam int CW    = $clog2(MAX_POINTS + 1);        // point count
    localparam int SW    = COORD_W + PAW;                 // coordinate sum
    localparam int VW    = (CW > VOXEL_W) ? CW : VOXEL_W; // divisor
    localparam int CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int CIW   = $clog2(CELLS);                 // cell address
    localparam int GW    = $clog2(GRID_DIM);              // per-axis index
    localparam int PTW   = 3 * COORD_W;                   // point word
    localparam int CWW   = CW + 3 * SW;                   // cell word

    typedef enum logic [4:0] {
        S_IDLE,
        S_MIN_RD,
        S_MIN_WAIT,
        S_CLR,
        S_BIN_RD,
        S_BIN_PT,
        S_BIN_DIVGO,
        S_BIN_DIVW,
        S_BIN_CHK,
        S_BIN_CELL_RD,
        S_BIN_CELL_WR,
        S_BIN_NEXT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MEAN_GO,
        S_MEAN_W,
        S_RESULT
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                     state_reg,   state_next;
    logic [VOXEL_W-1:0]         vs_reg,      vs_next;
    logic [CW-1:0]              loaded_reg,  loaded_next;
    logic                       dropped_reg, dropped_next;
    logic                       drain_reg,   drain_next;
    logic [CIW:0]               sp_reg,      sp_next;     // scan pointer
    logic [CW-1:0]              idx_reg,     idx_next;    // point index
    logic [CIW-1:0]             cidx_reg,    cidx_next;   // clear sweep
    logic [1:0]                 axis_reg,    axis_next;
    logic                       look_reg,    look_next;   // lookahead scan
    logic [CIW-1:0]             cell_reg,    cell_next;
    logic [CW-1:0]              cnt_reg,     cnt_next;
    logic signed [COORD_W-1:0]  min_reg  [3];
    logic signed [COORD_W-1:0]  min_next [3];
    logic signed [COORD_W-1:0]  pt_reg   [3];
    logic signed [COORD_W-1:0]  pt_next  [3];
    logic [COORD_W-1:0]         q_reg    [3];
    logic [COORD_W-1:0]         q_next   [3];
    logic signed [SW-1:0]       sum_reg  [3];
    logic signed [SW-1:0]       sum_next [3];
    logic [COORD_W-1:0]         rmean_reg  [3];
    logic [COORD_W-1:0]         rmean_next [3];
    logic [CW-1:0]              rcnt_reg,    rcnt_next;
    logic                       rlast_reg,   rlast_next;
    logic                       rempty_reg,  rempty_next;

    // output stage
    logic                       ov_reg,      ov_next;
    logic [COORD_W-1:0]         omx_reg,     omx_next;
    logic [COORD_W-1:0]         omy_reg,     omy_next;
    logic [COORD_W-1:0]         omz_reg,     omz_next;
    logic [CELL_PTS_W-1:0]      ocnt_reg,    ocnt_next;
    logic                       olast_reg,   olast_next;
    logic                       oempty_reg,  oempty_next;
    logic                       odrop_reg,   odrop_next;

    // ------------------------------------------------------------------
    // Memories and divider
    // ------------------------------------------------------------------
    logic               p_we;
    logic [PAW-1:0]     p_waddr;
    logic [PTW-1:0]     p_wdata;
    logic [PTW-1:0]     p_rdata;

    logic               c_we;
    logic [CIW-1:0]     c_waddr;
    logic [CWW-1:0]     c_wdata;
    logic [CIW-1:0]     c_raddr;
    logic [CWW-1:0]     c_rdata;

    logic               div_start;
    logic [SW-1:0]      div_dividend;
    logic [VW-1:0]      div_divisor;
    logic               div_done;
    logic [SW-1:0]      div_quot;
    logic               div_rnz;

    vgcd_ram #(
        .DEPTH (MAX_POINTS),
        .WIDTH (PTW)
    ) u_point_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (idx_reg[PAW-1:0]),
        .rdata (p_rdata)
    );

    vgcd_ram #(
        .DEPTH (CELLS),
        .WIDTH (CWW)
    ) u_cell_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    vgcd_divider #(
        .DW (SW),
        .VW (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot),
        .rem_nz   (div_rnz)
    );

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [VOXEL_W-1:0]         vs_eff;
    logic signed [COORD_W:0]    diff_ext;
    logic signed [COORD_W-1:0]  rd_coord [3];
    logic [CW-1:0]              rd_cnt;
    logic signed [SW-1:0]       rd_sum   [3];
    logic                       idx_last;
    logic                       in_grid;
    logic                       sum_neg;
    logic [SW-1:0]              sum_mag;
    logic [COORD_W-1:0]         qround;
    logic                       in_acc;
    logic                       out_free;

    always_comb
    begin
        // voxel_size of zero behaves as one
        vs_eff   = (vs_reg == '0) ? VOXEL_W'(1) : vs_reg;
        diff_ext = {pt_reg[axis_reg][COORD_W-1], pt_reg[axis_reg]}
                 - {min_reg[axis_reg][COORD_W-1], min_reg[axis_reg]};
        for (int a = 0; a < 3; a++)
        begin
            rd_coord[a] = p_rdata[a*COORD_W +: COORD_W];
            rd_sum[a]   = c_rdata[CW + a*SW +: SW];
        end
        rd_cnt   = c_rdata[CW-1:0];
        idx_last = (CW'(idx_reg + 1'b1) == loaded_reg);
        in_grid  = (q_reg[0] < COORD_W'(GRID_DIM)) && (q_reg[1] < COORD_W'(GRID_DIM))
                && (q_reg[2] < COORD_W'(GRID_DIM));
        sum_neg  = sum_reg[axis_reg][SW-1];
        sum_mag  = sum_neg ? (~sum_reg[axis_reg] + 1'b1) : sum_reg[axis_reg];
        qround   = div_quot[COORD_W-1:0] + COORD_W'(div_rnz);
        in_acc   = in_valid && in_ready;
        out_free = !ov_reg || out_ready;
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        vs_next      = vs_reg;
        loaded_next  = loaded_reg;
        dropped_next = dropped_reg;
        drain_next   = drain_reg;
        sp_next      = sp_reg;
        idx_next     = idx_reg;
        cidx_next    = cidx_reg;
        axis_next    = axis_reg;
        look_next    = look_reg;
        cell_next    = cell_reg;
        cnt_next     = cnt_reg;
        for (int a = 0; a < 3; a++)
        begin
            min_next[a]   = min_reg[a];
            pt_next[a]    = pt_reg[a];
            q_next[a]     = q_reg[a];
            sum_next[a]   = sum_reg[a];
            rmean_next[a] = rmean_reg[a];
        end
        rcnt_next    = rcnt_reg;
        rlast_next   = rlast_reg;
        rempty_next  = rempty_reg;

        ov_next      = ov_reg && !out_ready;
        omx_next     = omx_reg;
        omy_next     = omy_reg;
        omz_next     = omz_reg;
        ocnt_next    = ocnt_reg;
        olast_next   = olast_reg;
        oempty_next  = oempty_reg;
        odrop_next   = odrop_reg;

        p_we         = 1'b0;
        p_waddr      = loaded_reg[PAW-1:0];
        p_wdata      = {coord_z, coord_y, coord_x};
        c_we         = 1'b0;
        c_waddr      = cell_reg;
        c_wdata      = '0;
        c_raddr      = (state_reg == S_SCAN_RD) ? sp_reg[CIW-1:0] : cell_reg;
        div_start    = 1'b0;
        div_dividend = SW'(diff_ext[COORD_W-1:0]);
        div_divisor  = VW'(vs_eff);

        if (cfg_valid)
        begin
            vs_next = cfg_voxel_size;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && !mode)
                begin
                    // a load during drain abandons the cloud and starts over
                    if (drain_reg)
                    begin
                        drain_next   = 1'b0;
                        sp_next      = '0;
                        p_we         = 1'b1;
                        p_waddr      = '0;
                        loaded_next  = CW'(1);
                        dropped_next = 1'b0;
                    end
                    else if (loaded_reg < CW'(MAX_POINTS))
                    begin
                        p_we        = 1'b1;
                        loaded_next = loaded_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
                else if (in_acc)
                begin
                    rempty_next = 1'b0;
                    look_next   = 1'b0;
                    if (drain_reg)
                    begin
                        state_next = S_SCAN_RD;
                    end
                    else if (loaded_reg == '0)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            rmean_next[a] = '0;
                        end
                        rcnt_next   = '0;
                        rlast_next  = 1'b0;
                        rempty_next = 1'b1;
                        state_next  = S_RESULT;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_MIN_RD;
                    end
                end
            end

            S_MIN_RD:
            begin
                state_next = S_MIN_WAIT;
            end

            S_MIN_WAIT:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    if ((idx_reg == '0) || (rd_coord[a] < min_reg[a]))
                    begin
                        min_next[a] = rd_coord[a];
                    end
                end
                if (idx_last)
                begin
                    cidx_next  = '0;
                    state_next = S_CLR;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_MIN_RD;
                end
            end

            S_CLR:
            begin
                c_we    = 1'b1;
                c_waddr = cidx_reg;
                if (cidx_reg == CIW'(CELLS - 1))
                begin
                    idx_next   = '0;
                    state_next = S_BIN_RD;
                end
                else
                begin
                    cidx_next = cidx_reg + 1'b1;
                end
            end

            S_BIN_RD:
            begin
                state_next = S_BIN_PT;
            end

            S_BIN_PT:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    pt_next[a] = rd_coord[a];
                end
                axis_next  = '0;
                state_next = S_BIN_DIVGO;
            end

            S_BIN_DIVGO:
            begin
                div_start  = 1'b1;
                state_next = S_BIN_DIVW;
            end

            S_BIN_DIVW:
            begin
                if (div_done)
                begin
                    q_next[axis_reg] = div_quot[COORD_W-1:0];
                    if (axis_reg == 2'd2)
                    begin
                        state_next = S_BIN_CHK;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_BIN_DIVGO;
                    end
                end
            end

            S_BIN_CHK:
            begin
                if (in_grid)
                begin
                    cell_next  = CIW'(q_reg[0][GW-1:0])
                               + CIW'(GRID_DIM) * CIW'(q_reg[1][GW-1:0])
                               + CIW'(GRID_DIM * GRID_DIM) * CIW'(q_reg[2][GW-1:0]);
                    state_next = S_BIN_CELL_RD;
                end
                else
                begin
                    dropped_next = 1'b1;
                    state_next   = S_BIN_NEXT;
                end
            end

            S_BIN_CELL_RD:
            begin
                state_next = S_BIN_CELL_WR;
            end

            S_BIN_CELL_WR:
            begin
                c_we = 1'b1;
                c_wdata[CW-1:0] = rd_cnt + 1'b1;
                for (int a = 0; a < 3; a++)
                begin
                    c_wdata[CW + a*SW +: SW] = rd_sum[a]
                        + {{(SW-COORD_W){pt_reg[a][COORD_W-1]}}, pt_reg[a]};
                end
                state_next = S_BIN_NEXT;
            end

            S_BIN_NEXT:
            begin
                if (idx_last)
                begin
                    drain_next = 1'b1;
                    sp_next    = '0;
                    look_next  = 1'b0;
                    state_next = S_SCAN_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_BIN_RD;
                end
            end

            S_SCAN_RD:
            begin
                if (sp_reg == (CIW+1)'(CELLS))
                begin
                    // no filled cell left: this result closes the cloud
                    if (!look_reg)
                    begin
                        for (int a = 0; a < 3; a++)
                        begin
                            rmean_next[a] = '0;
                        end
                        rcnt_next = '0;
                    end
                    rlast_next = 1'b1;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end

            S_SCAN_CHK:
            begin
                if (rd_cnt != '0)
                begin
                    if (!look_reg)
                    begin
                        cnt_next = rd_cnt;
                        for (int a = 0; a < 3; a++)
                        begin
                            sum_next[a] = rd_sum[a];
                        end
                        axis_next  = '0;
                        state_next = S_MEAN_GO;
                    end
                    else
                    begin
                        rlast_next = 1'b0;
                        state_next = S_RESULT;
                    end
                end
                else
                begin
                    sp_next    = sp_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end

            S_MEAN_GO:
            begin
                div_start    = 1'b1;
                div_dividend = sum_mag;
                div_divisor  = VW'(cnt_reg);
                state_next   = S_MEAN_W;
            end

            S_MEAN_W:
            begin
                if (div_done)
                begin
                    // floor: round the magnitude up for negative sums
                    rmean_next[axis_reg] = sum_neg ? (~qround + 1'b1)
                                                   : div_quot[COORD_W-1:0];
                    if (axis_reg == 2'd2)
                    begin
                        rcnt_next  = cnt_reg;
                        sp_next    = sp_reg + 1'b1;
                        look_next  = 1'b1;
                        state_next = S_SCAN_RD;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = S_MEAN_GO;
                    end
                end
            end

            S_RESULT:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    omx_next    = rmean_reg[0];
                    omy_next    = rmean_reg[1];
                    omz_next    = rmean_reg[2];
                    ocnt_next   = CELL_PTS_W'(rcnt_reg);
                    olast_next  = rlast_reg;
                    oempty_next = rempty_reg;
                    odrop_next  = dropped_reg;
                    if (rlast_reg)
                    begin
                        drain_next   = 1'b0;
                        loaded_next  = '0;
                        dropped_next = 1'b0;
                        sp_next      = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            vs_reg      <= VOXEL_RESET;
            loaded_reg  <= '0;
            dropped_reg <= 1'b0;
            drain_reg   <= 1'b0;
            sp_reg      <= '0;
            idx_reg     <= '0;
            cidx_reg    <= '0;
            axis_reg    <= '0;
            look_reg    <= 1'b0;
            cell_reg    <= '0;
            cnt_reg     <= '0;
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a]   <= '0;
                pt_reg[a]    <= '0;
                q_reg[a]     <= '0;
                sum_reg[a]   <= '0;
                rmean_reg[a] <= '0;
            end
            rcnt_reg    <= '0;
            rlast_reg   <= 1'b0;
            rempty_reg  <= 1'b0;
            ov_reg      <= 1'b0;
            omx_reg     <= '0;
            omy_reg     <= '0;
            omz_reg     <= '0;
            ocnt_reg    <= '0;
            olast_reg   <= 1'b0;
            oempty_reg  <= 1'b0;
            odrop_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            vs_reg      <= vs_next;
            loaded_reg  <= loaded_next;
            dropped_reg <= dropped_next;
            drain_reg   <= drain_next;
            sp_reg      <= sp_next;
            idx_reg     <= idx_next;
            cidx_reg    <= cidx_next;
            axis_reg    <= axis_next;
            look_reg    <= look_next;
            cell_reg    <= cell_next;
            cnt_reg     <= cnt_next;
            for (int a = 0; a < 3; a++)
            begin
                min_reg[a]   <= min_next[a];
                pt_reg[a]    <= pt_next[a];
                q_reg[a]     <= q_next[a];
                sum_reg[a]   <= sum_next[a];
                rmean_reg[a] <= rmean_next[a];
            end
            rcnt_reg    <= rcnt_next;
            rlast_reg   <= rlast_next;
            rempty_reg  <= rempty_next;
            ov_reg      <= ov_next;
            omx_reg     <= omx_next;
            omy_reg     <= omy_next;
            omz_reg     <= omz_next;
            ocnt_reg    <= ocnt_next;
            olast_reg   <= olast_next;
            oempty_reg  <= oempty_next;
            odrop_reg   <= odrop_next;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign cfg_ready      = 1'b1;
    assign in_ready       = (state_reg == S_IDLE);
    assign out_valid      = ov_reg;
    assign mean_x         = omx_reg;
    assign mean_y         = omy_reg;
    assign mean_z         = omz_reg;
    assign cell_points    = ocnt_reg;
    assign last_cell      = olast_reg;
    assign cloud_empty    = oempty_reg;
    assign points_dropped = odrop_reg;

endmodule

/* rtl/core/vgcd_checker.sv */
// ----------------------------------------------------------------------------
// vgcd_checker
// Port-level checks on the result channel of the downsampler.
// ----------------------------------------------------------------------------
module vgcd_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [vgcd_pkg::COORD_W-1:0] mean_x,
    input logic signed [vgcd_pkg::COORD_W-1:0] mean_y,
    input logic signed [vgcd_pkg::COORD_W-1:0] mean_z,
    input logic [vgcd_pkg::CELL_PTS_W-1:0]     cell_points,
    input logic                                last_cell,
    input logic                                cloud_empty,
    input logic                                points_dropped
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // an empty cloud carries nothing else
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cloud_empty |-> mean_x == 0 && mean_y == 0 && mean_z == 0
            && cell_points == 0 && !last_cell && !points_dropped)
        else $error("empty-cloud result carries data");

    // a result that is not the last cell comes from a filled cell
    a_mid_filled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cloud_empty && !last_cell |-> cell_points != 0)
        else $error("intermediate result from an empty cell");

    // no filled cell at all only happens when every point was dropped
    a_none_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cloud_empty && cell_points == 0 |-> last_cell && points_dropped)
        else $error("cell-less result without dropped points");

endmodule

bind voxel_grid_centroid_downsampler_top vgcd_checker u_vgcd_checker (.*);
